// ===== rtl/tle_pkg.sv =====
// Package for the tone table editor: widths, command codes, shared types and functions.
// No dependencies.
package tle_pkg;
    localparam int TableDepth = 256;
    localparam int EntryBits = 12;
    localparam int AddrBits = 8;
    localparam int FactorBits = 24;
    localparam int Lanes = 3;

    typedef logic signed [EntryBits-1:0] entry_t;

    typedef enum logic [2:0] {
        CMD_APPLY     = 3'd0,
        CMD_RESET     = 3'd1,
        CMD_BRIGHTEN  = 3'd2,
        CMD_DARKEN    = 3'd3,
        CMD_INVERT    = 3'd4,
        CMD_THRESHOLD = 3'd5,
        CMD_CON_UP    = 3'd6,
        CMD_CON_DOWN  = 3'd7
    } cmd_t;

    function automatic logic [7:0] clamp_byte(input entry_t v);
        logic [7:0] r;
        if (v < 0) r = 8'd0;
        else if (v > entry_t'(255)) r = 8'd255;
        else r = v[7:0];
        return r;
    endfunction

    function automatic entry_t sat_entry(input logic signed [EntryBits+1:0] v);
        entry_t r;
        if (v > (EntryBits+2)'(2**(EntryBits-1)-1)) r = {1'b0, {(EntryBits-1){1'b1}}};
        else if (v < -(EntryBits+2)'(2**(EntryBits-1))) r = {1'b1, {(EntryBits-1){1'b0}}};
        else r = v[EntryBits-1:0];
        return r;
    endfunction
endpackage

// ===== rtl/tle_divider.sv =====
// Restoring divider, one quotient bit per cycle, for the contrast factor.
// Depends on tle_pkg.
module tle_divider (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            start,
    input  logic [41:0]                     num,
    input  logic [17:0]                     den,
    output logic                            done,
    output logic [tle_pkg::FactorBits-1:0]  quot
);
    logic [41:0] q_reg;
    logic [18:0] rem_reg;
    logic [5:0]  cnt_reg;
    logic        busy_reg;
    logic [17:0] den_reg;
    logic [18:0] trial;

    assign trial = {rem_reg[17:0], q_reg[41]};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done     <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                q_reg    <= num;
                rem_reg  <= '0;
                den_reg  <= den;
                cnt_reg  <= 6'd42;
            end else if (busy_reg) begin
                if (trial >= {1'b0, den_reg}) begin
                    rem_reg <= trial - {1'b0, den_reg};
                    q_reg   <= {q_reg[40:0], 1'b1};
                end else begin
                    rem_reg <= trial;
                    q_reg   <= {q_reg[40:0], 1'b0};
                end
                cnt_reg <= cnt_reg - 6'd1;
                if (cnt_reg == 6'd1) begin
                    busy_reg <= 1'b0;
                    done     <= 1'b1;
                end
            end
        end
    end

    assign quot = q_reg[tle_pkg::FactorBits-1:0];
endmodule

// ===== rtl/tle_lane.sv =====
// One table lane: a private copy of the tone table, a lookup read port and the edit
// pipeline that rewrites the copy one entry per cycle. Depends on tle_pkg.
module tle_lane (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  tle_pkg::cmd_t                  cmd,
    input  logic [7:0]                     amount,
    input  logic [tle_pkg::FactorBits-1:0] factor,
    input  logic                           rd_en,
    input  logic                           sweep,
    input  logic [tle_pkg::AddrBits-1:0]   rd_addr,
    output tle_pkg::entry_t                rdata
);
    tle_pkg::entry_t mem [tle_pkg::TableDepth];
    tle_pkg::entry_t rdata_reg;
    logic [tle_pkg::AddrBits-1:0] a1_reg;
    logic [tle_pkg::AddrBits-1:0] a2_reg;
    logic v1_reg;
    logic v2_reg;
    logic signed [tle_pkg::EntryBits+1:0] xe;
    tle_pkg::entry_t simple;
    tle_pkg::entry_t simple_reg;
    logic signed [tle_pkg::EntryBits:0] d_reg;
    logic signed [tle_pkg::EntryBits+26:0] s;
    tle_pkg::entry_t y;

    always_ff @(posedge aclk) begin
        if (rd_en) rdata_reg <= mem[rd_addr];
        if (v2_reg) mem[a2_reg] <= y;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else begin
            v1_reg <= sweep;
            v2_reg <= v1_reg;
        end
    end

    assign xe = (tle_pkg::EntryBits+2)'(rdata_reg);

    always_comb begin
        case (cmd)
            tle_pkg::CMD_RESET:    simple = tle_pkg::entry_t'(a1_reg);
            tle_pkg::CMD_BRIGHTEN:
                simple = tle_pkg::sat_entry(xe + (tle_pkg::EntryBits+2)'(amount));
            tle_pkg::CMD_DARKEN:
                simple = tle_pkg::sat_entry(xe - (tle_pkg::EntryBits+2)'(amount));
            tle_pkg::CMD_INVERT:
                simple = tle_pkg::sat_entry((tle_pkg::EntryBits+2)'(255) - xe);
            tle_pkg::CMD_THRESHOLD:
                simple = (a1_reg <= 8'd128) ? tle_pkg::entry_t'(0) : tle_pkg::entry_t'(255);
            default:               simple = rdata_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        a1_reg     <= rd_addr;
        a2_reg     <= a1_reg;
        d_reg      <= (tle_pkg::EntryBits+1)'(rdata_reg) - (tle_pkg::EntryBits+1)'(128);
        simple_reg <= simple;
    end

    assign s = (tle_pkg::EntryBits+27)'(d_reg) * $signed({1'b0, factor})
             + (tle_pkg::EntryBits+27)'(32'sd8388608);

    always_comb begin
        if (cmd == tle_pkg::CMD_CON_UP || cmd == tle_pkg::CMD_CON_DOWN) begin
            if (s < 0) y = '0;
            else if (s[tle_pkg::EntryBits+25:16] > (tle_pkg::EntryBits+10)'(255))
                y = tle_pkg::entry_t'(255);
            else y = tle_pkg::entry_t'(s[23:16]);
        end else begin
            y = simple_reg;
        end
    end

    assign rdata = rdata_reg;
endmodule

// ===== rtl/tone_lut_editor_and_apply.sv =====
// Top level of the tone table editor: control, contrast factor divider, three table
// lanes and the merge of their outputs. Depends on tle_pkg, tle_divider, tle_lane.
// Each lane keeps its own copy of the 256-entry tone table, one per color; all copies
// get the same edits, so the red, green and blue lookups of an apply run side by side.
// After reset the lanes load the identity ramp in a 256-entry pass, so s_ready stays
// low until that pass completes. An apply reads the three tables at acceptance into
// the lane read registers and then registers the clamped samples in the result
// register; no new command is accepted before that. An edit sweeps all entries one
// per cycle in every lane through the v1_reg/v2_reg write pipeline, after the factor
// divider on contrast commands. One command is in flight at a time.
module tone_lut_editor_and_apply (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [2:0] s_command,
    input  logic [7:0] s_amount,
    input  logic [7:0] s_in_red,
    input  logic [7:0] s_in_green,
    input  logic [7:0] s_in_blue,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_out_red,
    output logic [7:0] m_out_green,
    output logic [7:0] m_out_blue,
    output logic       m_is_pixel
);
    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_APPLY = 5'b00010,
        ST_DIV   = 5'b00100,
        ST_EDIT  = 5'b01000,
        ST_DONE  = 5'b10000
    } state_t;

    state_t state_reg;
    tle_pkg::cmd_t cmd_reg;
    logic [7:0] amount_reg;
    logic [tle_pkg::FactorBits-1:0] factor_reg;
    logic [tle_pkg::AddrBits-1:0] addr_reg;
    logic [1:0] wv_reg;
    logic       init_reg;
    logic       m_valid_reg;
    logic [7:0] out_red_reg;
    logic [7:0] out_green_reg;
    logic [7:0] out_blue_reg;
    logic       is_pixel_reg;
    logic       div_done;
    logic [tle_pkg::FactorBits-1:0] quot;
    logic [41:0] num;
    logic [17:0] den;
    tle_pkg::cmd_t s_cmd;
    logic       accept;
    logic       is_contrast;
    logic       sweep;
    logic       rd_en;
    logic       load_px;
    logic       load_edit;
    logic [tle_pkg::AddrBits-1:0] sample [tle_pkg::Lanes];
    logic [tle_pkg::AddrBits-1:0] lane_addr [tle_pkg::Lanes];
    tle_pkg::entry_t lane_data [tle_pkg::Lanes];

    assign s_cmd = tle_pkg::cmd_t'(s_command);
    assign s_ready = (state_reg == ST_IDLE) && (!m_valid_reg || m_ready);
    assign accept = s_valid && s_ready;
    assign is_contrast = (s_cmd == tle_pkg::CMD_CON_UP) || (s_cmd == tle_pkg::CMD_CON_DOWN);
    assign sweep = (state_reg == ST_EDIT);
    assign rd_en = sweep || (accept && s_cmd == tle_pkg::CMD_APPLY);
    assign load_px = (state_reg == ST_APPLY);
    assign load_edit = (state_reg == ST_DONE) && (wv_reg == 2'b00) && !init_reg;

    assign sample[0] = s_in_red;
    assign sample[1] = s_in_green;
    assign sample[2] = s_in_blue;

    always_comb begin
        if (s_cmd == tle_pkg::CMD_CON_UP) begin
            num = 42'(18'd259 * (18'(s_amount) + 18'd255)) << 16;
            den = 18'(18'd255 * (18'd259 - 18'(s_amount)));
        end else begin
            num = 42'(18'd259 * (18'd255 - 18'(s_amount))) << 16;
            den = 18'(18'd255 * (18'd259 + 18'(s_amount)));
        end
    end

    tle_divider u_div (
        .aclk(aclk), .aresetn(aresetn),
        .start(accept && is_contrast),
        .num(num), .den(den), .done(div_done), .quot(quot)
    );

    for (genvar l = 0; l < tle_pkg::Lanes; l++) begin : g_lane
        assign lane_addr[l] = sweep ? addr_reg : sample[l];
        tle_lane u_lane (
            .aclk(aclk), .aresetn(aresetn), .cmd(cmd_reg), .amount(amount_reg),
            .factor(factor_reg), .rd_en(rd_en), .sweep(sweep), .rd_addr(lane_addr[l]),
            .rdata(lane_data[l])
        );
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_EDIT;
            cmd_reg    <= tle_pkg::CMD_RESET;
            amount_reg <= '0;
            factor_reg <= '0;
            addr_reg   <= '0;
            wv_reg     <= '0;
            init_reg   <= 1'b1;
        end else begin
            wv_reg <= {wv_reg[0], sweep};
            unique case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        cmd_reg    <= s_cmd;
                        amount_reg <= s_amount;
                        addr_reg   <= '0;
                        if (s_cmd == tle_pkg::CMD_APPLY) state_reg <= ST_APPLY;
                        else if (is_contrast) state_reg <= ST_DIV;
                        else state_reg <= ST_EDIT;
                    end
                end
                ST_APPLY: begin
                    state_reg <= ST_IDLE;
                end
                ST_DIV: begin
                    if (div_done) begin
                        factor_reg <= quot;
                        state_reg  <= ST_EDIT;
                    end
                end
                ST_EDIT: begin
                    addr_reg <= addr_reg + 8'd1;
                    if (addr_reg == '1) state_reg <= ST_DONE;
                end
                ST_DONE: begin
                    if (wv_reg == 2'b00) begin
                        init_reg  <= 1'b0;
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // merge stage: clamp the lane lookups into the result register, or zero it for an edit completion
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (load_px || load_edit) begin
            m_valid_reg <= 1'b1;
        end else if (m_valid_reg && m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_px) begin
            out_red_reg   <= tle_pkg::clamp_byte(lane_data[0]);
            out_green_reg <= tle_pkg::clamp_byte(lane_data[1]);
            out_blue_reg  <= tle_pkg::clamp_byte(lane_data[2]);
            is_pixel_reg  <= 1'b1;
        end else if (load_edit) begin
            out_red_reg   <= '0;
            out_green_reg <= '0;
            out_blue_reg  <= '0;
            is_pixel_reg  <= 1'b0;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_out_red   = out_red_reg;
    assign m_out_green = out_green_reg;
    assign m_out_blue  = out_blue_reg;
    assign m_is_pixel  = is_pixel_reg;
endmodule

// ===== rtl/tle_checker.sv =====
// Port-level checker for the tone table editor, bound to the top level.
// Depends on tle_pkg and the tone_lut_editor_and_apply ports.
module tle_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_valid,
    input logic       s_ready,
    input logic [2:0] s_command,
    input logic       m_valid,
    input logic       m_ready,
    input logic [7:0] m_out_red,
    input logic [7:0] m_out_green,
    input logic [7:0] m_out_blue,
    input logic       m_is_pixel
);
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_out_red) && $stable(m_is_pixel))
        else $error("result changed while stalled");
    a_edit_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_is_pixel |-> m_out_red == 8'd0 && m_out_green == 8'd0 &&
        m_out_blue == 8'd0)
        else $error("edit completion carries data");
    a_apply_next: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_command == tle_pkg::CMD_APPLY |=> ##1 m_valid && m_is_pixel)
        else $error("apply result missing");
    a_edit_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_command != tle_pkg::CMD_APPLY |=> !s_ready)
        else $error("took transfer during edit");
endmodule

bind tone_lut_editor_and_apply tle_checker u_chk (.*);
